### hdl/assert_macros.svh
// Assertion macros shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSA_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TSA_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tsa_pkg.sv
// Types and constants of the timing statistics accumulator.
`default_nettype none
package tsa_pkg;

    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [6:0] DIV_BITS_CONV = 7'd40;
    localparam logic [6:0] DIV_BITS_MEAN = 7'd32;
    localparam logic [6:0] DIV_BITS_JIT  = 7'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_CONV,
        ST_MEAN_GO,
        ST_MEAN,
        ST_MULT,
        ST_SPREAD,
        ST_WRITE,
        ST_JIT_GO,
        ST_JIT,
        ST_SQRT,
        ST_DONE
    } tsa_state_t;

    typedef enum logic [1:0] {
        DIV_CONV,
        DIV_MEAN,
        DIV_JIT
    } tsa_div_sel_t;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] mean;
        logic [63:0] spread;
        logic [31:0] last;
        logic [31:0] peak;
    } tsa_entry_t;

    typedef struct packed {
        logic         req_ready;
        logic         clear_all;
        logic         load_entry;
        logic         div_start;
        tsa_div_sel_t div_sel;
        logic         conv_take;
        logic         d1_take;
        logic         mean_take;
        logic         mult_take;
        logic         spread_take;
        logic         entry_write;
        logic         jit_zero;
        logic         sqrt_start;
        logic         jit_take;
        logic         out_load;
    } tsa_cmd_t;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] func;
        logic       act;
        logic       count_gt1;
        logic       div_done;
        logic       sqrt_done;
        logic       out_free;
    } tsa_sts_t;

endpackage
`default_nettype wire

### hdl/tsa_ifs.sv
// Channel interfaces: request, response and configuration write.
`default_nettype none
interface tsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  quantity;
    logic [31:0] start_tick;
    logic [31:0] now_cycle;
    modport source (output valid, func, quantity, start_tick, now_cycle, input ready);
    modport sink   (input valid, func, quantity, start_tick, now_cycle, output ready);
endinterface

interface tsa_rsp_if;
    logic        valid;
    logic        ready;
    logic        quantity_ok;
    logic [31:0] sample_count;
    logic [31:0] last_us;
    logic [31:0] mean_us;
    logic [31:0] max_us;
    logic [31:0] jitter_us;
    modport source (output valid, quantity_ok, sample_count, last_us, mean_us, max_us,
                    jitter_us, input ready);
    modport sink   (input valid, quantity_ok, sample_count, last_us, mean_us, max_us,
                    jitter_us, output ready);
endinterface

interface tsa_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] ticks_per_us;
    modport source (output valid, ticks_per_us, input ready);
    modport sink   (input valid, ticks_per_us, output ready);
endinterface
`default_nettype wire

### hdl/tsa_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
`default_nettype none
module tsa_div
    import tsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    input  wire logic [6:0]  nbits,
    output logic             done,
    output logic [63:0]      quotient
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        fits;

    // The dividend arrives left-aligned, so after nbits shifts only quotient bits remain.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[63]};
        diff      = shifted - {1'b0, dsr_reg};
        fits      = shifted >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[31:0] : shifted[31:0];
            quo_next = {quo_reg[62:0], fits};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

### hdl/tsa_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
`default_nettype none
module tsa_sqrt
    import tsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [34:0] raw;
    logic [34:0] trial;

    always_comb
    begin
        raw       = {rem_reg, x_reg[63:62]};
        trial     = {1'b0, res_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = radicand;
            rem_next  = '0;
            res_next  = '0;
        end
        else if (busy_reg)
        begin
            x_next   = {x_reg[61:0], 2'b00};
            cnt_next = cnt_reg + 5'd1;
            if (raw >= trial)
            begin
                rem_next = 33'(raw - trial);
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = raw[32:0];
                res_next = {res_reg[30:0], 1'b0};
            end
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule
`default_nettype wire

### hdl/tsa_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
`default_nettype none
module tsa_ctrl
    import tsa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tsa_sts_t sts,
    output tsa_cmd_t      cmd
);
    tsa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (sts.req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.func == FUNC_CLEAR)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (!sts.act)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_entry = 1'b1;
                if (sts.func == FUNC_RECORD)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CONV;
                    state_next    = ST_CONV;
                end
                else
                begin
                    state_next = ST_JIT_GO;
                end
            end
            ST_CONV:
            begin
                if (sts.div_done)
                begin
                    cmd.conv_take = 1'b1;
                    state_next    = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:
            begin
                cmd.d1_take   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                state_next    = ST_MEAN;
            end
            ST_MEAN:
            begin
                cmd.div_sel = DIV_MEAN;
                if (sts.div_done)
                begin
                    cmd.mean_take = 1'b1;
                    state_next    = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mult_take = 1'b1;
                state_next    = ST_SPREAD;
            end
            ST_SPREAD:
            begin
                cmd.spread_take = 1'b1;
                state_next      = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.entry_write = 1'b1;
                state_next      = ST_JIT_GO;
            end
            ST_JIT_GO:
            begin
                if (sts.count_gt1)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_JIT;
                    state_next    = ST_JIT;
                end
                else
                begin
                    cmd.jit_zero = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_JIT:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.jit_take = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register can take the result.
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/tsa_dp.sv
// Datapath: statistics store, Welford update, shared divider and square root unit.
`default_nettype none
module tsa_dp
    import tsa_pkg::*;
#(
    parameter int NUM_QUANTITIES = 8
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tsa_req_if.sink     req,
    tsa_rsp_if.source   rsp,
    tsa_cfg_if.sink     cfg,
    input  wire tsa_cmd_t cmd,
    output tsa_sts_t    sts
);
    localparam int QW = (NUM_QUANTITIES > 1) ? $clog2(NUM_QUANTITIES) : 1;

    tsa_entry_t  mem [NUM_QUANTITIES];
    logic [NUM_QUANTITIES-1:0] vld_reg;

    logic [9:0]  cpu_reg;
    logic [1:0]  func_reg;
    logic        inrange_reg;
    logic [QW-1:0] qidx_reg;
    logic [31:0] elapsed_reg;
    tsa_entry_t  rd_reg;
    logic        rdv_reg;
    tsa_entry_t  res_reg;
    logic [31:0] val_reg;
    logic [31:0] d1_reg;
    logic        ge_reg;
    logic [63:0] prod_reg;
    logic [31:0] jit_reg;
    logic        rsp_valid_reg;
    logic        ok_reg;
    tsa_entry_t  out_reg;
    logic [31:0] out_jit_reg;

    logic        accept;
    logic        act;
    tsa_entry_t  old_entry;
    logic [9:0]  div_cpu;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic [6:0]  div_nbits;
    logic        div_done;
    logic [63:0] div_quo;
    logic        sqrt_done;
    logic [31:0] sqrt_root;
    logic [31:0] val_sat;
    logic        ge_c;
    logic [31:0] d1_c;
    logic [31:0] d2_c;
    logic [63:0] prod_c;
    logic [64:0] sum_c;

    assign accept    = req.valid && cmd.req_ready;
    assign req.ready = cmd.req_ready;
    assign cfg.ready = 1'b1;
    assign act       = inrange_reg && (func_reg == FUNC_RECORD || func_reg == FUNC_READ);
    assign old_entry = rdv_reg ? rd_reg : '0;
    assign div_cpu   = (cpu_reg == 10'd0) ? 10'd1 : cpu_reg;
    assign val_sat   = (|div_quo[63:32]) ? '1 : div_quo[31:0];
    assign ge_c      = val_reg >= res_reg.mean;
    assign d1_c      = ge_c ? (val_reg - res_reg.mean) : (res_reg.mean - val_reg);
    assign d2_c      = ge_reg ? (val_reg - res_reg.mean) : (res_reg.mean - val_reg);
    assign prod_c    = {32'd0, d1_reg} * {32'd0, d2_c};
    assign sum_c     = {1'b0, res_reg.spread} + {1'b0, prod_reg};

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_CONV:
            begin
                div_dividend = {elapsed_reg, 8'd0, 24'd0};
                div_divisor  = {22'd0, div_cpu};
                div_nbits    = DIV_BITS_CONV;
            end
            DIV_MEAN:
            begin
                div_dividend = {d1_c, 32'd0};
                div_divisor  = res_reg.count;
                div_nbits    = DIV_BITS_MEAN;
            end
            DIV_JIT:
            begin
                div_dividend = res_reg.spread;
                div_divisor  = res_reg.count - 32'd1;
                div_nbits    = DIV_BITS_JIT;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 32'd1;
                div_nbits    = DIV_BITS_MEAN;
            end
        endcase
    end

    tsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .done     (div_done),
        .quotient (div_quo)
    );

    tsa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (div_quo),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Control registers: configuration, valid bits, output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_reg       <= 10'd1;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cpu_reg <= cfg.ticks_per_us;
            end
            if (cmd.clear_all)
            begin
                vld_reg <= '0;
            end
            else if (cmd.entry_write)
            begin
                vld_reg[qidx_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg  <= mem[qidx_reg];
        rdv_reg <= vld_reg[qidx_reg];
        if (cmd.entry_write)
        begin
            mem[qidx_reg] <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            inrange_reg <= {1'b0, req.quantity} < 9'(NUM_QUANTITIES);
            qidx_reg    <= req.quantity[QW-1:0];
            elapsed_reg <= req.now_cycle - req.start_tick;
        end
        if (cmd.load_entry)
        begin
            res_reg <= old_entry;
        end
        else if (cmd.conv_take)
        begin
            res_reg.last  <= val_sat;
            res_reg.count <= (res_reg.count == '1) ? res_reg.count : res_reg.count + 32'd1;
            res_reg.peak  <= (val_sat > res_reg.peak) ? val_sat : res_reg.peak;
        end
        else if (cmd.mean_take)
        begin
            res_reg.mean <= ge_reg ? (res_reg.mean + div_quo[31:0])
                                   : (res_reg.mean - div_quo[31:0]);
        end
        else if (cmd.spread_take)
        begin
            res_reg.spread <= sum_c[64] ? '1 : sum_c[63:0];
        end
        if (cmd.conv_take)
        begin
            val_reg <= val_sat;
        end
        if (cmd.d1_take)
        begin
            d1_reg <= d1_c;
            ge_reg <= ge_c;
        end
        if (cmd.mult_take)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.jit_zero)
        begin
            jit_reg <= '0;
        end
        else if (cmd.jit_take)
        begin
            jit_reg <= sqrt_root;
        end
        // Drop every data field to zero unless the request was acted on; quantity_ok is also set for a clear.
        if (cmd.out_load)
        begin
            ok_reg      <= act || (func_reg == FUNC_CLEAR);
            out_reg     <= act ? res_reg : '0;
            out_jit_reg <= act ? jit_reg : '0;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.quantity_ok  = ok_reg;
    assign rsp.sample_count = out_reg.count;
    assign rsp.last_us      = out_reg.last;
    assign rsp.mean_us      = out_reg.mean;
    assign rsp.max_us       = out_reg.peak;
    assign rsp.jitter_us    = out_jit_reg;

    assign sts.req_valid = req.valid;
    assign sts.func      = func_reg;
    assign sts.act       = act;
    assign sts.count_gt1 = res_reg.count > 32'd1;
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.out_free  = !rsp_valid_reg || rsp.ready;
endmodule
`default_nettype wire

### hdl/timing_stats_accumulator.sv
// Timing statistics accumulator, top level.
// Keeps count, last, mean, maximum and sample standard deviation (Welford) of
// durations for NUM_QUANTITIES quantities, values in unsigned Q24.8 microseconds.
// One transaction is in flight at a time. A record runs, in order, the
// cycles-to-microseconds division, the mean division, the spread-over-count
// division and the square root, all bit-serial on one shared divider and one
// root unit, with control states between them. A record that leaves the count
// at one skips the last two steps. A read runs the spread-over-count division
// and the root only, and skips both when the count is at most one; a clear or a
// rejected request runs neither. A finished result waits in the output register
// while the next transaction is taken. ticks_per_us may be written only while
// the block is idle.
`default_nettype none
module timing_stats_accumulator
    import tsa_pkg::*;
#(
    parameter int NUM_QUANTITIES = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tsa_req_if.sink   req,
    tsa_rsp_if.source rsp,
    tsa_cfg_if.sink   cfg
);
    tsa_cmd_t cmd;
    tsa_sts_t sts;

    tsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    tsa_dp #(
        .NUM_QUANTITIES (NUM_QUANTITIES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );
endmodule
`default_nettype wire

### hdl/tsa_checker.sv
// Port-level checker for the timing statistics accumulator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module tsa_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        quantity_ok,
    input wire logic [31:0] sample_count,
    input wire logic [31:0] last_us,
    input wire logic [31:0] mean_us,
    input wire logic [31:0] max_us,
    input wire logic [31:0] jitter_us
);
    `TSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `TSA_ASSERT_NOW(a_reject_zero, rsp_valid && !quantity_ok, sample_count == 32'd0 && last_us == 32'd0 && mean_us == 32'd0 && max_us == 32'd0 && jitter_us == 32'd0, "rejected response carries data")
    `TSA_ASSERT_NOW(a_jit_small, rsp_valid && sample_count <= 32'd1, jitter_us == 32'd0, "jitter nonzero with at most one sample")
    `TSA_ASSERT_NOW(a_max_bound, rsp_valid, max_us >= mean_us && max_us >= last_us, "maximum below mean or last value")
endmodule

bind timing_stats_accumulator tsa_checker u_tsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .quantity_ok  (rsp.quantity_ok),
    .sample_count (rsp.sample_count),
    .last_us      (rsp.last_us),
    .mean_us      (rsp.mean_us),
    .max_us       (rsp.max_us),
    .jitter_us    (rsp.jitter_us)
);
`default_nettype wire
